// ----- src/pep_pkg.sv -----
// Shared types and constants for the postfix expression evaluator.
package pep_pkg;

    // Character codes recognized in the expression stream
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 3;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_DIVZERO   = 3'd2,
        ST_BADCHAR   = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_EXTRA     = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic push;     // push a new top, spill old top to memory
        logic replace;  // pop two, push one: count down, new top
        logic clear;    // drop the whole stack
        logic rd;       // fetch the entry under the top
    } stk_cmd_t;

endpackage

// ----- src/pep_if.sv -----
// Valid/ready channel interfaces for expression characters and results.
interface pep_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface pep_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pep_pkg::VALUE_W-1:0]    value;
    logic        [pep_pkg::STATUS_W-1:0]   status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

// ----- src/pep_stack.sv -----
// Operand stack: top held in a register, deeper entries in a memory.
module pep_stack #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pep_pkg::stk_cmd_t                    cmd,
    input  logic [DATA_WIDTH-1:0]                push_data,
    input  logic [DATA_WIDTH-1:0]                wr_data,
    output logic [DATA_WIDTH-1:0]                tos,
    output logic [DATA_WIDTH-1:0]                rd_data,
    output logic [$clog2(STACK_DEPTH+1)-1:0]     count
);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] tos_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic [CW-1:0]         cm1;
    logic [CW-1:0]         cm2;

    assign cm1 = count_reg - CW'(1);
    assign cm2 = count_reg - CW'(2);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clear)
        begin
            count_next = '0;
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.replace)
        begin
            count_next = cm1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Spill the old top on push; fetch the second entry on request
    always_ff @(posedge clk)
    begin
        if (cmd.push && (count_reg != '0))
        begin
            mem[cm1[AW-1:0]] <= tos_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[cm2[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            tos_reg <= push_data;
        end
        else if (cmd.replace)
        begin
            tos_reg <= wr_data;
        end
    end

    assign tos     = tos_reg;
    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

// ----- src/pep_alu.sv -----
// Shared bit-serial unit: shift-add multiply and restoring signed divide.
module pep_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pep_pkg::alu_cmd_t     cmd,
    input  logic [DATA_WIDTH-1:0] op_a,
    input  logic [DATA_WIDTH-1:0] op_b,
    output logic [DATA_WIDTH-1:0] res,
    output pep_pkg::alu_stat_t    stat
);
    localparam int W   = DATA_WIDTH;
    localparam int CNW = $clog2(W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNW-1:0]   cnt_reg;
    pep_pkg::alu_op_t op_reg;
    logic             neg_reg;
    logic [W-1:0]     x_reg;
    logic [W-1:0]     y_reg;
    logic [W:0]       acc_reg;

    logic [W-1:0]     abs_a;
    logic [W-1:0]     abs_b;
    logic [W:0]       rem_sh;
    logic [W:0]       rem_sub;
    logic             rem_ge;

    assign abs_a   = op_a[W-1] ? (W'(0) - op_a) : op_a;
    assign abs_b   = op_b[W-1] ? (W'(0) - op_b) : op_b;
    assign rem_sh  = {acc_reg[W-1:0], x_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, y_reg};
    assign rem_ge  = (rem_sh >= {1'b0, y_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNW'(1);
                if (cnt_reg == CNW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            neg_reg <= op_a[W-1] ^ op_b[W-1];
            acc_reg <= '0;
            if (cmd.op == pep_pkg::ALU_DIV)
            begin
                x_reg <= abs_a;
                y_reg <= abs_b;
            end
            else
            begin
                x_reg <= op_a;
                y_reg <= op_b;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == pep_pkg::ALU_DIV)
            begin
                // Shift in the next dividend bit, subtract when it fits
                acc_reg <= rem_ge ? rem_sub : rem_sh;
                x_reg   <= {x_reg[W-2:0], rem_ge};
            end
            else
            begin
                if (y_reg[0])
                begin
                    acc_reg <= {1'b0, acc_reg[W-1:0] + x_reg};
                end
                x_reg <= {x_reg[W-2:0], 1'b0};
                y_reg <= {1'b0, y_reg[W-1:1]};
            end
        end
    end

    always_comb
    begin
        if (op_reg == pep_pkg::ALU_DIV)
        begin
            res = neg_reg ? (W'(0) - x_reg) : x_reg;
        end
        else
        begin
            res = acc_reg[W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- src/postfix_expression_evaluator.sv -----
// Top level: postfix expression evaluator with operand stack and shared arithmetic unit.
//
//  channel | dir | payload                         | transfer
//  --------+-----+---------------------------------+-------------------------
//  expr    | in  | char_code[7:0], last_char       | valid & ready at clk edge
//  result  | out | value[31:0] signed, status[2:0] | valid & ready at clk edge
//
// Per item: a digit is pushed straight from decode; + and - go through the
// operand fetch; * and / use the shared multiply/divide unit (one bit per cycle);
// ^ needs up to one multiply and one squaring per exponent bit in that unit.
// The end mark adds a final check of the stack. Reset (rst_n, asynchronous)
// empties the stack and clears the error flag. A finished result waits in the
// output register; input is taken only when idle, so it also stalls while a second result waits.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    pep_in_if.sink           expr,
    pep_out_if.source        result
);
    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    // Sequencer states, one-hot
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_READ   = 9'b000000100,
        S_ALU    = 9'b000001000,
        S_POW    = 9'b000010000,
        S_PWR    = 9'b000100000,
        S_PWB    = 9'b001000000,
        S_END    = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t                       state_reg, state_next;
    logic [7:0]                   char_reg, char_next;
    logic                         last_reg, last_next;
    logic                         skip_reg, skip_next;
    logic [W-1:0]                 pr_reg, pr_next;    // power: running result
    logic [W-1:0]                 pb_reg, pb_next;    // power: running base
    logic [W-1:0]                 pe_reg, pe_next;    // power: remaining exponent
    logic [pep_pkg::VALUE_W-1:0]  pend_val_reg, pend_val_next;
    pep_pkg::status_t             pend_st_reg, pend_st_next;
    logic                         out_valid_reg, out_valid_next;
    logic [pep_pkg::VALUE_W-1:0]  out_val_reg, out_val_next;
    pep_pkg::status_t             out_st_reg, out_st_next;

    pep_pkg::stk_cmd_t            stk_cmd;
    logic [W-1:0]                 stk_push_data;
    logic [W-1:0]                 stk_wr_data;
    logic [W-1:0]                 stk_tos;
    logic [W-1:0]                 stk_rd_data;
    logic [CW-1:0]                stk_count;

    pep_pkg::alu_cmd_t            alu_cmd;
    logic [W-1:0]                 alu_a;
    logic [W-1:0]                 alu_b;
    logic [W-1:0]                 alu_res;
    pep_pkg::alu_stat_t           alu_stat;

    logic                         in_fire;
    logic                         is_digit;
    logic                         is_op;
    logic                         commit_en;
    logic [W-1:0]                 commit_val;
    logic [W-1:0]                 pow_neg_val;
    logic signed [63:0]           tos_ext;

    pep_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .DATA_WIDTH  (DATA_WIDTH)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .push_data (stk_push_data),
        .wr_data   (stk_wr_data),
        .tos       (stk_tos),
        .rd_data   (stk_rd_data),
        .count     (stk_count)
    );

    pep_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .op_a  (alu_a),
        .op_b  (alu_b),
        .res   (alu_res),
        .stat  (alu_stat)
    );

    assign expr.ready = (state_reg == S_IDLE);
    assign in_fire    = expr.valid && expr.ready;

    assign is_digit = (char_reg >= pep_pkg::CH_ZERO) && (char_reg <= pep_pkg::CH_NINE);
    assign is_op    = (char_reg == pep_pkg::CH_PLUS)  || (char_reg == pep_pkg::CH_MINUS) ||
                      (char_reg == pep_pkg::CH_STAR)  || (char_reg == pep_pkg::CH_SLASH) ||
                      (char_reg == pep_pkg::CH_CARET);

    // Digit value, zero-extended to the data width
    assign stk_push_data = {{(W-4){1'b0}}, 4'(char_reg - pep_pkg::CH_ZERO)};
    assign stk_wr_data   = commit_val;

    // Final value: sign-extend the stack word, keep the low 32 bits
    assign tos_ext = 64'(signed'(stk_tos));

    // Negative exponent: 1 for base 1, +/-1 for base -1 by parity, else 0
    always_comb
    begin
        if (stk_rd_data == W'(1))
        begin
            pow_neg_val = W'(1);
        end
        else if (stk_rd_data == {W{1'b1}})
        begin
            pow_neg_val = stk_tos[0] ? {W{1'b1}} : W'(1);
        end
        else
        begin
            pow_neg_val = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        skip_next      = skip_reg;
        pr_next        = pr_reg;
        pb_next        = pb_reg;
        pe_next        = pe_reg;
        pend_val_next  = pend_val_reg;
        pend_st_next   = pend_st_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && !result.ready;
        stk_cmd        = '0;
        alu_cmd.start  = 1'b0;
        alu_cmd.op     = pep_pkg::ALU_MUL;
        alu_a          = stk_rd_data;
        alu_b          = stk_tos;
        commit_en      = 1'b0;
        commit_val     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    char_next = expr.char_code;
                    last_next = expr.last_char;
                    if (skip_reg)
                    begin
                        // Drop characters after an error; end mark restarts
                        if (expr.last_char)
                        begin
                            skip_next     = 1'b0;
                            stk_cmd.clear = 1'b1;
                        end
                    end
                    else
                    begin
                        state_next = S_DECODE;
                    end
                end
            end

            S_DECODE:
            begin
                pend_val_next = '0;
                if (is_digit && (stk_count != CW'(STACK_DEPTH)))
                begin
                    stk_cmd.push = 1'b1;
                    state_next   = last_reg ? S_END : S_IDLE;
                end
                else if (is_op && (stk_count >= CW'(2)))
                begin
                    stk_cmd.rd = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    if (is_digit)
                    begin
                        pend_st_next = pep_pkg::ST_OVERFLOW;
                    end
                    else if (!is_op)
                    begin
                        pend_st_next = pep_pkg::ST_BADCHAR;
                    end
                    else
                    begin
                        pend_st_next = pep_pkg::ST_UNDERFLOW;
                    end
                    if (last_reg)
                    begin
                        stk_cmd.clear = 1'b1;
                    end
                    else
                    begin
                        skip_next = 1'b1;
                    end
                    state_next = S_EMIT;
                end
            end

            S_READ:
            begin
                // a is the second entry, b the top
                case (char_reg)
                    pep_pkg::CH_PLUS:
                    begin
                        commit_en  = 1'b1;
                        commit_val = stk_rd_data + stk_tos;
                    end
                    pep_pkg::CH_MINUS:
                    begin
                        commit_en  = 1'b1;
                        commit_val = stk_rd_data - stk_tos;
                    end
                    pep_pkg::CH_STAR:
                    begin
                        alu_cmd.start = 1'b1;
                        alu_cmd.op    = pep_pkg::ALU_MUL;
                        state_next    = S_ALU;
                    end
                    pep_pkg::CH_SLASH:
                    begin
                        if (stk_tos == '0)
                        begin
                            pend_val_next = '0;
                            pend_st_next  = pep_pkg::ST_DIVZERO;
                            if (last_reg)
                            begin
                                stk_cmd.clear = 1'b1;
                            end
                            else
                            begin
                                skip_next = 1'b1;
                            end
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = pep_pkg::ALU_DIV;
                            state_next    = S_ALU;
                        end
                    end
                    pep_pkg::CH_CARET:
                    begin
                        if (stk_tos[W-1])
                        begin
                            commit_en  = 1'b1;
                            commit_val = pow_neg_val;
                        end
                        else
                        begin
                            pr_next    = W'(1);
                            pb_next    = stk_rd_data;
                            pe_next    = stk_tos;
                            state_next = S_POW;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_ALU:
            begin
                if (alu_stat.done)
                begin
                    commit_en  = 1'b1;
                    commit_val = alu_res;
                end
            end

            S_POW:
            begin
                alu_cmd.op = pep_pkg::ALU_MUL;
                if (pe_reg == '0)
                begin
                    commit_en  = 1'b1;
                    commit_val = pr_reg;
                end
                else if (pe_reg[0])
                begin
                    // Fold the base into the result for this exponent bit
                    alu_cmd.start = 1'b1;
                    alu_a         = pr_reg;
                    alu_b         = pb_reg;
                    state_next    = S_PWR;
                end
                else
                begin
                    // Advance to the next exponent bit and square the base
                    alu_cmd.start = 1'b1;
                    alu_a         = pb_reg;
                    alu_b         = pb_reg;
                    pe_next       = {1'b0, pe_reg[W-1:1]};
                    state_next    = S_PWB;
                end
            end

            S_PWR:
            begin
                if (alu_stat.done)
                begin
                    pr_next    = alu_res;
                    pe_next    = {pe_reg[W-1:1], 1'b0};
                    state_next = S_POW;
                end
            end

            S_PWB:
            begin
                if (alu_stat.done)
                begin
                    pb_next    = alu_res;
                    state_next = S_POW;
                end
            end

            S_END:
            begin
                if (stk_count == '0)
                begin
                    pend_val_next = '0;
                    pend_st_next  = pep_pkg::ST_EMPTY;
                end
                else if (stk_count > CW'(1))
                begin
                    pend_val_next = '0;
                    pend_st_next  = pep_pkg::ST_EXTRA;
                end
                else
                begin
                    pend_val_next = tos_ext[pep_pkg::VALUE_W-1:0];
                    pend_st_next  = pep_pkg::ST_OK;
                end
                stk_cmd.clear = 1'b1;
                state_next    = S_EMIT;
            end

            S_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = pend_val_reg;
                    out_st_next    = pend_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit_en)
        begin
            stk_cmd.replace = 1'b1;
            state_next      = last_reg ? S_END : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            skip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            skip_reg      <= skip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg     <= char_next;
        last_reg     <= last_next;
        pr_reg       <= pr_next;
        pb_reg       <= pb_next;
        pe_reg       <= pe_next;
        pend_val_reg <= pend_val_next;
        pend_st_reg  <= pend_st_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
    end

    assign result.valid  = out_valid_reg;
    assign result.value  = signed'(out_val_reg);
    assign result.status = out_st_reg;

    // Stack fill never passes its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stk_count <= CW'(STACK_DEPTH))
        else $error("operand stack count exceeds depth");

    // An operator reaches the operand fetch only with two values stored
    a_read_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (stk_count >= CW'(2)))
        else $error("operator fetch with fewer than two operands");

    // While waiting on the shared unit, it is running or just finished
    a_alu_wait: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ALU) || (state_reg == S_PWR) || (state_reg == S_PWB))
            |-> (alu_stat.busy || alu_stat.done))
        else $error("sequencer waits on an idle arithmetic unit");

    // A new result is loaded only into a free or draining output register
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EMIT) && out_valid_reg && !result.ready) |=> (state_reg == S_EMIT))
        else $error("result overwritten while output still held");

endmodule

// ----- dv/postfix_expression_evaluator_test.sv -----
// Self-checking testbench for the postfix expression evaluator.
`timescale 1ns / 100ps

module postfix_expression_evaluator_test;

    localparam int STACK_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 600;
    // Long receiver hold-off in the last phase: enough to fill the output
    // register and stall the character input behind it.
    localparam int LONG_HOLD    = 400;
    // A ^ with a full 31-bit exponent needs up to one multiply and one squaring per
    // exponent bit. The drain wait after the last result outlasts such a ^, to
    // catch any stray one.
    localparam int DRAIN_CYCLES = 2400;
    // Slowest correct run: about 800 characters, each a worst-case ^, take
    // about 14 ms; allow several times that.
    localparam int WATCHDOG_NS  = 100_000_000;

    typedef struct packed {
        logic signed [pep_pkg::VALUE_W-1:0] value;
        pep_pkg::status_t                   status;
    } expr_result_t;

    // Predicts the result of each expression and checks the results the block
    // returns, in order.
    class rpn_checker;
        logic [pep_pkg::VALUE_W-1:0] operands[STACK_DEPTH];
        int unsigned                 depth;
        bit                          skipping;
        expr_result_t                pending_results[$];
        int                          failures;
        int                          checked;
        int                          live_chars;
        int                          status_seen[8];

        // Signed division on magnitudes, truncated toward zero. The most
        // negative value over minus one wraps back to the most negative value.
        function logic [pep_pkg::VALUE_W-1:0] quotient(logic [pep_pkg::VALUE_W-1:0] a,
                                                       logic [pep_pkg::VALUE_W-1:0] b);
            logic [pep_pkg::VALUE_W-1:0] ma, mb, q;
            ma = a[pep_pkg::VALUE_W-1] ? -a : a;
            mb = b[pep_pkg::VALUE_W-1] ? -b : b;
            q  = ma / mb;
            return (a[pep_pkg::VALUE_W-1] ^ b[pep_pkg::VALUE_W-1]) ? -q : q;
        endfunction

        // Exponentiation by repeated squaring, wrapping at the data width.
        function logic [pep_pkg::VALUE_W-1:0] power(logic [pep_pkg::VALUE_W-1:0] a,
                                                    logic [pep_pkg::VALUE_W-1:0] b);
            logic [pep_pkg::VALUE_W-1:0] acc, base, e;
            if (b[pep_pkg::VALUE_W-1])
            begin
                // Negative exponent: only 1 and -1 survive.
                if (a == pep_pkg::VALUE_W'(1))
                    return pep_pkg::VALUE_W'(1);
                if (a == '1)
                    return b[0] ? '1 : pep_pkg::VALUE_W'(1);
                return '0;
            end
            acc  = pep_pkg::VALUE_W'(1);
            base = a;
            e    = b;
            while (e != '0)
            begin
                if (e[0])
                    acc = acc * base;
                base = base * base;
                e    = e >> 1;
            end
            return acc;
        endfunction

        function pep_pkg::status_t apply_char(logic [7:0] code);
            logic [pep_pkg::VALUE_W-1:0] a, b, r;
            if (code >= pep_pkg::CH_ZERO && code <= pep_pkg::CH_NINE)
            begin
                if (depth >= STACK_DEPTH)
                    return pep_pkg::ST_OVERFLOW;
                operands[depth] = {24'd0, code - pep_pkg::CH_ZERO};
                depth++;
                return pep_pkg::ST_OK;
            end
            if (!(code inside {pep_pkg::CH_PLUS, pep_pkg::CH_MINUS, pep_pkg::CH_STAR,
                               pep_pkg::CH_SLASH, pep_pkg::CH_CARET}))
                return pep_pkg::ST_BADCHAR;
            if (depth < 2)
                return pep_pkg::ST_UNDERFLOW;
            b = operands[depth-1];
            a = operands[depth-2];
            case (code)
                pep_pkg::CH_PLUS:  r = a + b;
                pep_pkg::CH_MINUS: r = a - b;
                pep_pkg::CH_STAR:  r = a * b;
                pep_pkg::CH_SLASH:
                begin
                    if (b == '0)
                        return pep_pkg::ST_DIVZERO;
                    r = quotient(a, b);
                end
                default:  r = power(a, b);
            endcase
            depth--;
            operands[depth-1] = r;
            return pep_pkg::ST_OK;
        endfunction

        // Note one accepted character and queue the result it causes, if any.
        function void take_char(logic [7:0] code, logic last);
            pep_pkg::status_t st;
            expr_result_t     want;
            if (!skipping)
            begin
                live_chars++;
                st         = apply_char(code);
                want.value = '0;
                if (st != pep_pkg::ST_OK)
                begin
                    want.status = st;
                    pending_results.push_back(want);
                    skipping = 1'b1;
                end
                else if (last)
                begin
                    if (depth == 0)
                        want.status = pep_pkg::ST_EMPTY;
                    else if (depth > 1)
                        want.status = pep_pkg::ST_EXTRA;
                    else
                    begin
                        want.status = pep_pkg::ST_OK;
                        want.value  = operands[0];
                    end
                    pending_results.push_back(want);
                end
            end
            if (last)
            begin
                depth    = 0;
                skipping = 1'b0;
            end
        endfunction

        function void note_failure(string msg);
            failures++;
            if (failures <= 10)
                $display("mismatch at %0t ns: %s", $time, msg);
        endfunction

        function void compare_result(logic signed [pep_pkg::VALUE_W-1:0] value,
                                     logic [pep_pkg::STATUS_W-1:0] status);
            expr_result_t want;
            checked++;
            status_seen[status]++;
            if (pending_results.size() == 0)
            begin
                note_failure($sformatf("result with nothing expected: value %0d status %0d",
                                       value, status));
                return;
            end
            want = pending_results.pop_front();
            if (value !== want.value || status !== want.status)
                note_failure($sformatf("expected value %0d status %0d, got value %0d status %0d",
                                       want.value, want.status, value, status));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    pep_in_if  expr_ch ();
    pep_out_if result_ch ();

    postfix_expression_evaluator i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .expr   (expr_ch),
        .result (result_ch)
    );

    rpn_checker board = new();

    // Idle rates of the two sides, in percent; changed per phase.
    int src_idle_pct  = 9;
    int sink_idle_pct = 52;
    // Raised by the stimulus to ask the receiver for one long hold-off.
    bit hold_request  = 1'b0;

    // Characters of the expression being built.
    logic [7:0] expr_chars[$];
    int         expr_count = 0;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Expression builders
    // ------------------------------------------------------------------

    function automatic void add_digit(int lo, int hi);
        expr_chars.push_back(pep_pkg::CH_ZERO + 8'($urandom_range(lo, hi)));
    endfunction

    function automatic logic [7:0] pick_operator();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25)
            return pep_pkg::CH_PLUS;
        if (pick < 45)
            return pep_pkg::CH_MINUS;
        if (pick < 70)
            return pep_pkg::CH_STAR;
        if (pick < 90)
            return pep_pkg::CH_SLASH;
        return pep_pkg::CH_CARET;
    endfunction

    // Append one well-formed operand: a digit, a negation (0 x -), or a
    // binary operation on two smaller operands. Depth stays below lvl + 2.
    function automatic void add_operand(int lvl);
        int pick;
        pick = $urandom_range(0, 9);
        if (lvl == 0 || pick < 4)
            add_digit(0, 9);
        else if (pick == 4)
        begin
            expr_chars.push_back(pep_pkg::CH_ZERO);
            add_operand(lvl - 1);
            expr_chars.push_back(pep_pkg::CH_MINUS);
        end
        else
        begin
            add_operand(lvl - 1);
            add_operand(lvl - 1);
            expr_chars.push_back(pick_operator());
        end
    endfunction

    // Build the next random expression. Mostly well-formed with random
    // content; the rest goes after the edges of ^, broken expressions,
    // random bytes, and stacks deep enough to fill or overflow.
    function automatic void make_expression();
        int         kind;
        int         n;
        logic [7:0] code;
        expr_chars = {};
        kind       = $urandom_range(0, 199);
        if (kind < 120)
            add_operand($urandom_range(0, 4));
        else if (kind < 140)
        begin
            // Base of 0, 1, -1 or anything, raised to zero, negative or any.
            case ($urandom_range(0, 3))
                0: add_digit(0, 1);
                1:
                begin
                    expr_chars.push_back(pep_pkg::CH_ZERO);
                    add_digit(1, 1);
                    expr_chars.push_back(pep_pkg::CH_MINUS);
                end
                2: add_digit(0, 9);
                default: add_operand(2);
            endcase
            case ($urandom_range(0, 2))
                0: add_digit(0, 0);
                1:
                begin
                    expr_chars.push_back(pep_pkg::CH_ZERO);
                    add_operand(2);
                    expr_chars.push_back(pep_pkg::CH_MINUS);
                end
                default: add_operand(2);
            endcase
            expr_chars.push_back(pep_pkg::CH_CARET);
        end
        else if (kind < 180)
        begin
            add_operand($urandom_range(1, 3));
            case ($urandom_range(0, 4))
                0:
                begin
                    // Bad character somewhere in the expression.
                    do
                        code = 8'($urandom_range(0, 255));
                    while (code inside {[pep_pkg::CH_ZERO:pep_pkg::CH_NINE],
                                        pep_pkg::CH_PLUS, pep_pkg::CH_MINUS,
                                        pep_pkg::CH_STAR, pep_pkg::CH_SLASH,
                                        pep_pkg::CH_CARET});
                    expr_chars.insert($urandom_range(0, expr_chars.size()), code);
                end
                1:
                begin
                    if (expr_chars.size() > 1)
                        void'(expr_chars.pop_back());
                end
                2: expr_chars.push_front(pick_operator());
                3:
                begin
                    expr_chars.push_back(pep_pkg::CH_ZERO);
                    expr_chars.push_back(pep_pkg::CH_SLASH);
                end
                default: add_digit(0, 9);
            endcase
        end
        else if (kind < 197)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                expr_chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            // Fill the stack close to, to or past its depth, then fold it back down.
            n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 1);
            repeat (n)
                add_digit(0, 9);
            repeat (n - 1)
                expr_chars.push_back(($urandom_range(0, 2) == 0) ? pep_pkg::CH_PLUS :
                                     ($urandom_range(0, 1) == 0) ? pep_pkg::CH_MINUS :
                                                                   pep_pkg::CH_STAR);
        end
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one character after a random gap; return at the edge that takes it.
    // Valid stays high on return so back-to-back items need no second update.
    task automatic send_char(input logic [7:0] code, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            expr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        expr_ch.valid     <= 1'b1;
        expr_ch.char_code <= code;
        expr_ch.last_char <= last;
        do
            @(posedge clk);
        while (!expr_ch.ready);
        board.take_char(code, last);
    endtask

    task automatic send_expression();
        for (int i = 0; i < expr_chars.size(); i++)
            send_char(expr_chars[i], i == expr_chars.size() - 1);
        expr_count++;
    endtask

    task automatic send_text(input string text);
        expr_chars = {};
        for (int i = 0; i < text.len(); i++)
            expr_chars.push_back(text[i]);
        send_expression();
    endtask

    // Receiver: check each accepted result, then pick the next ready level.
    // A long hold-off is counted down here, while the sender keeps going.
    initial
    begin : result_sink
        int hold_left;
        hold_left       = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                board.compare_result(result_ch.value, result_ch.status);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin : watchdog
        #(WATCHDOG_NS);
        $display("FAIL postfix_expression_evaluator");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int base_live;
        rst_n             <= 1'b0;
        expr_ch.valid     <= 1'b0;
        expr_ch.char_code <= 8'h00;
        expr_ch.last_char <= 1'b0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: most negative over minus one (built as 2^31 and 0-1),
        // division by zero, underflow on the end character, underflow then
        // skip to the end, bad characters at both byte extremes, extra
        // operands, and a negative exponent. An empty result cannot arise:
        // any accepted character leaves at least one value on the stack.
        send_text("248*1-^01-/");
        send_text("90/");
        send_text("+");
        send_text("5+3");
        expr_chars = {8'h00};
        send_expression();
        expr_chars = {8'hFF};
        send_expression();
        send_text("12");
        send_text("201-^");

        // Random: three phases of idling, the last with the long hold-off.
        base_live = board.live_chars;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 9;
                    sink_idle_pct = 52;
                end
                1:
                begin
                    src_idle_pct  = 52;
                    sink_idle_pct = 9;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    hold_request  = 1'b1;
                end
            endcase
            while (board.live_chars - base_live < (phase + 1) * RANDOM_ITEMS / 3)
            begin
                make_expression();
                send_expression();
            end
        end
        expr_ch.valid <= 1'b0;

        // Drain: every expression yields one result; then watch for strays.
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("covered %0d expressions, %0d evaluated characters, %0d results checked",
                 expr_count, board.live_chars, board.checked);
        $display("statuses: ok %0d underflow %0d div-zero %0d bad-char %0d extra %0d overflow %0d",
                 board.status_seen[pep_pkg::ST_OK], board.status_seen[pep_pkg::ST_UNDERFLOW],
                 board.status_seen[pep_pkg::ST_DIVZERO], board.status_seen[pep_pkg::ST_BADCHAR],
                 board.status_seen[pep_pkg::ST_EXTRA], board.status_seen[pep_pkg::ST_OVERFLOW]);
        if (board.failures == 0)
            $display("PASS postfix_expression_evaluator");
        else
            $display("FAIL postfix_expression_evaluator");
        $finish;
    end

endmodule
